FILE: design/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// shared constants, codes and beat types of the bounded deque store
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int CAPACITY      = 256;
  localparam int ELEMENT_WIDTH = 32;

  // beat field widths
  localparam int KIND_W  = 3;
  localparam int DATA_W  = 32;
  localparam int POS_W   = 10;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 9;

  // storage geometry
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  // input data is 32 bits, so the stored element width is clamped to at most that
  localparam int ELEM_W = (ELEMENT_WIDTH < DATA_W) ? ELEMENT_WIDTH : DATA_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_HEAD = 3'd0,
    KIND_INS_TAIL = 3'd1,
    KIND_REM_HEAD = 3'd2,
    KIND_REM_TAIL = 3'd3,
    KIND_RD_HEAD  = 3'd4,
    KIND_RD_TAIL  = 3'd5,
    KIND_RD_POS   = 3'd6
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE  = 1'b0,
    FSM_FETCH = 1'b1
  } fsm_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] element_data;
    logic [POS_W-1:0]  position;
  } in_beat_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] count;
  } out_beat_t;

  // one access to the element store
  typedef struct packed {
    logic              we;
    logic              re;
    logic [IDX_W-1:0]  addr;
    logic [ELEM_W-1:0] wdata;
  } mem_req_t;

  // result info held while the store read is in flight
  typedef struct packed {
    logic               use_mem;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } pend_t;

endpackage

FILE: design/bounded_deque_store.sv
// ----------------------------------------------------------------------------
// bounded_deque_store
// bounded double-ended list held as a ring buffer in one synchronous ram
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake               | beat
//   --------+-----------+-------------------------+------------------------
//   in      | input     | in_valid_i / in_stall_o | kind, element_data, position
//   out     | output    | out_valid_o/ out_stall_i| read_data, status, count
//
// an operation is accepted together with its store access; in the fetch state the
// registered ram read data is then merged into the output register once it is free
// one result beat per operation, in order
// reset clears head pointer, count, state and output valid; ram contents stay
// in_stall_o is high during the fetch state; a held result in the output
// register does not block the next accept, only its completion
//
module bounded_deque_store
  import bdq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  fsm_e              state_q, state_d;
  logic              accept;
  logic              load_out;
  logic              out_valid_q, out_valid_d;
  out_beat_t         out_beat_q;
  mem_req_t          req;
  pend_t             pend;
  logic [ELEM_W-1:0] rdata;

  // pointer and count bookkeeping, address generation
  bdq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (accept),
    .beat_i (in_beat_i),
    .req_o  (req),
    .pend_o (pend)
  );

  // element store
  bdq_ram #(
    .Depth (CAPACITY),
    .Width (ELEM_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req.we),
    .re_i    (req.re),
    .addr_i  (req.addr),
    .wdata_i (req.wdata),
    .rdata_o (rdata)
  );

  // output register can take a result when empty or being drained
  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          state_d = FSM_FETCH;
        end
      end
      FSM_FETCH: begin
        if (out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        in_stall_o = 1'b0;
      end
      FSM_FETCH: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  // output valid: set on load, cleared once the beat is taken
  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_stall_i) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload: ram data only where the operation read a held entry
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_beat_q.read_data <= pend.use_mem ? DATA_W'(rdata) : '0;
      out_beat_q.status    <= pend.status;
      out_beat_q.count     <= pend.count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

FILE: design/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// single-port synchronous ram, registered read data, no reset on contents
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int Depth = 256,
  parameter int Width = 32,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// operation decode, head pointer and count, store address generation
// ----------------------------------------------------------------------------
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     go_i,
  input  in_beat_t beat_i,
  output mem_req_t req_o,
  output pend_t    pend_o
);

  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  pend_t            pend_q, pend_d;

  logic             is_full, is_empty, pos_range, pos_held;
  logic [IDX_W-1:0] pos_idx, tail_idx, cnt_idx;

  // ring slot of list offset i, i below capacity
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [IDX_W-1:0] ofs);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, ofs};
    if (sum >= (IDX_W+1)'(CAPACITY)) begin
      sum = sum - (IDX_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign is_full   = (count_q >= CNT_W'(CAPACITY));
  assign is_empty  = (count_q == '0);
  assign pos_range = ({1'b0, beat_i.position} >= (POS_W+1)'(CAPACITY));
  assign pos_held  = ((POS_W+1)'(beat_i.position) < (POS_W+1)'(count_q));
  assign pos_idx   = IDX_W'(beat_i.position);
  assign cnt_idx   = IDX_W'(count_q);
  assign tail_idx  = IDX_W'(count_q - CNT_W'(1));

  always_comb begin
    head_d         = head_q;
    count_d        = count_q;
    req_o.we       = 1'b0;
    req_o.re       = 1'b0;
    req_o.addr     = head_q;
    req_o.wdata    = beat_i.element_data[ELEM_W-1:0];
    pend_d.use_mem = 1'b0;
    pend_d.status  = STAT_OK;
    case (kind_e'(beat_i.kind))
      KIND_INS_HEAD: begin
        if (is_full) begin
          pend_d.status = STAT_FULL;
        end else begin
          head_d     = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - IDX_W'(1);
          req_o.we   = go_i;
          req_o.addr = head_d;
          count_d    = count_q + CNT_W'(1);
        end
      end
      KIND_INS_TAIL: begin
        if (is_full) begin
          pend_d.status = STAT_FULL;
        end else begin
          req_o.we   = go_i;
          req_o.addr = slot_of(head_q, cnt_idx);
          count_d    = count_q + CNT_W'(1);
        end
      end
      KIND_REM_HEAD: begin
        if (is_empty) begin
          pend_d.status = STAT_EMPTY;
        end else begin
          head_d  = slot_of(head_q, IDX_W'(1));
          count_d = count_q - CNT_W'(1);
        end
      end
      KIND_REM_TAIL: begin
        if (!is_empty) begin
          count_d = count_q - CNT_W'(1);
        end
      end
      KIND_RD_HEAD: begin
        if (is_empty) begin
          pend_d.status = STAT_EMPTY;
        end else begin
          req_o.re       = go_i;
          pend_d.use_mem = 1'b1;
        end
      end
      KIND_RD_TAIL: begin
        if (is_empty) begin
          pend_d.status = STAT_EMPTY;
        end else begin
          req_o.re       = go_i;
          req_o.addr     = slot_of(head_q, tail_idx);
          pend_d.use_mem = 1'b1;
        end
      end
      KIND_RD_POS: begin
        if (pos_range) begin
          pend_d.status = STAT_RANGE;
        end else if (pos_held) begin
          req_o.re       = go_i;
          req_o.addr     = slot_of(head_q, pos_idx);
          pend_d.use_mem = 1'b1;
        end
      end
      default: begin
      end
    endcase
    pend_d.count = COUNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (go_i) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      pend_q <= pend_d;
    end
  end

  assign pend_o = pend_q;

endmodule

FILE: tb/sv/bounded_deque_store_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_store_tb
// self-checking bench for the bounded deque store: a directed list of
// operations around empty and out-of-range cases, then random
// operation mixes that fill the deque to capacity and wrap the ring,
// all scored against an in-bench deque model with random idling on
// both channels
// ----------------------------------------------------------------------------
module bounded_deque_store_tb;
  import bdq_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_CYCLES = 9;
  localparam int TIMEOUT_NS  = 5_000_000;
  localparam int MIX_ITEMS   = 100;  // balanced items before the fill phase
  localparam int TAIL_ITEMS  = 80;   // balanced items after the fill phase
  localparam int CALM_ITEMS  = 60;   // last items run with no idling
  localparam int OVERFILL    = 6;    // fill-mix operations sent once the deque is full

  // only the low ELEM_W bits of an element are kept
  localparam logic [DATA_W-1:0] ELEM_MASK = {DATA_W{1'b1}} >> (DATA_W - ELEM_W);

  typedef enum {MIX_BALANCED, MIX_FILL} mix_e;

  // one directed step; want is only used when typed is set
  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  // deque model state, advanced once per accepted input beat
  logic [DATA_W-1:0] ring_mem [CAPACITY];
  int                ring_head  = 0;
  int                deque_fill = 0;

  out_beat_t pending_results [$];
  dir_row_t  dir_rows [$];
  int        fail_cnt  = 0;
  int        sent_ops  = 0;
  int        gap_rate  = 0;
  bit        calm      = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  bounded_deque_store i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  // apply one operation to the model and return the result beat it gives
  function automatic out_beat_t deque_apply(in_beat_t b);
    out_beat_t         r;
    logic [DATA_W-1:0] d;
    r        = '0;
    r.status = STAT_OK;
    d        = b.element_data & ELEM_MASK;
    case (kind_e'(b.kind))
      KIND_INS_HEAD: begin
        if (deque_fill >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          ring_head = (ring_head == 0) ? CAPACITY - 1 : ring_head - 1;
          ring_mem[ring_head] = d;
          deque_fill++;
        end
      end
      KIND_INS_TAIL: begin
        if (deque_fill >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          ring_mem[(ring_head + deque_fill) % CAPACITY] = d;
          deque_fill++;
        end
      end
      KIND_REM_HEAD: begin
        if (deque_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          ring_head = (ring_head + 1) % CAPACITY;
          deque_fill--;
        end
      end
      // removing the tail of an empty deque is silently ok
      KIND_REM_TAIL: begin
        if (deque_fill != 0) deque_fill--;
      end
      KIND_RD_HEAD: begin
        if (deque_fill == 0) r.status = STAT_EMPTY;
        else r.read_data = ring_mem[ring_head];
      end
      KIND_RD_TAIL: begin
        if (deque_fill == 0) r.status = STAT_EMPTY;
        else r.read_data = ring_mem[(ring_head + deque_fill - 1) % CAPACITY];
      end
      // positions past the count but inside capacity read as zero
      KIND_RD_POS: begin
        if (b.position >= CAPACITY) r.status = STAT_RANGE;
        else if (b.position < deque_fill)
          r.read_data = ring_mem[(ring_head + b.position) % CAPACITY];
      end
      default: ;
    endcase
    r.count = COUNT_W'(deque_fill);
    return r;
  endfunction

  function automatic void add_row(kind_e k, logic [DATA_W-1:0] d, logic [POS_W-1:0] p,
                                  bit typed, status_e st, int cnt);
    dir_row_t row;
    row.beat.kind         = k;
    row.beat.element_data = d;
    row.beat.position     = p;
    row.typed             = typed;
    row.want.read_data    = '0;
    row.want.status       = st;
    row.want.count        = COUNT_W'(cnt);
    dir_rows.push_back(row);
  endfunction

  // random operation; fill mode leans hard on inserts to reach capacity
  function automatic in_beat_t random_op(mix_e mix);
    in_beat_t b;
    int       r;
    int       p;
    r = $urandom_range(0, 99);
    if (mix == MIX_FILL) begin
      if (r < 45)      b.kind = KIND_INS_HEAD;
      else if (r < 90) b.kind = KIND_INS_TAIL;
      else if (r < 92) b.kind = KIND_REM_HEAD;
      else if (r < 94) b.kind = KIND_REM_TAIL;
      else if (r < 96) b.kind = KIND_RD_HEAD;
      else if (r < 98) b.kind = KIND_RD_TAIL;
      else             b.kind = KIND_RD_POS;
    end else begin
      if (r < 22)      b.kind = KIND_INS_HEAD;
      else if (r < 44) b.kind = KIND_INS_TAIL;
      else if (r < 56) b.kind = KIND_REM_HEAD;
      else if (r < 68) b.kind = KIND_REM_TAIL;
      else if (r < 76) b.kind = KIND_RD_HEAD;
      else if (r < 84) b.kind = KIND_RD_TAIL;
      else             b.kind = KIND_RD_POS;
    end
    b.element_data = $urandom;
    // mostly live positions, some dead slots, some past capacity
    p = $urandom_range(0, 9);
    if (p < 6)      b.position = (deque_fill > 0) ?
                                 POS_W'($urandom_range(0, deque_fill - 1)) : '0;
    else if (p < 8) b.position = POS_W'($urandom_range(0, CAPACITY - 1));
    else            b.position = POS_W'($urandom_range(CAPACITY, (1 << POS_W) - 1));
    return b;
  endfunction

  // present one beat, hold it through stalls, record the expected result
  task automatic send_op(in_beat_t b, bit typed, out_beat_t want);
    out_beat_t predicted;
    int        gap;
    if (sent_ops % 32 == 0) gap_rate = $urandom_range(0, 3);
    if (!calm && $urandom_range(0, 7) < gap_rate) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk_i); while (in_stall);
    predicted = deque_apply(b);
    pending_results.push_back(typed ? want : predicted);
    sent_ops++;
  endtask

  // drop valid at once and wait for every outstanding result
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // receiver stall: random bursts, rate re-picked now and then
  initial begin
    int stall_left;
    int stall_rate;
    int cyc;
    stall_left = 0;
    stall_rate = 0;
    cyc        = 0;
    forever begin
      @(negedge clk_i);
      if (cyc % 64 == 0) stall_rate = $urandom_range(0, 4);
      cyc++;
      if (stall_left > 0 && !calm) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = 0;
        out_stall <= 1'b0;
        if (!calm && $urandom_range(0, 7) < stall_rate) stall_left = $urandom_range(1, 6);
      end
    end
  end

  // score every accepted result beat against the oldest expectation
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no pending operation: data %h status %0d count %0d",
               out_beat.read_data, out_beat.status, out_beat.count);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_beat.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_beat.read_data);
          fail_cnt++;
        end
        if (out_beat.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_beat.status);
          fail_cnt++;
        end
        if (out_beat.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_beat.count);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    out_beat_t none;
    int        n;
    none = '0;

    // empty deque corner cases, then a small list to read back
    add_row(KIND_RD_HEAD,  32'h0000_0000, 10'd0,    1, STAT_EMPTY, 0);
    add_row(KIND_RD_TAIL,  32'h0000_0000, 10'd0,    1, STAT_EMPTY, 0);
    add_row(KIND_REM_HEAD, 32'h0000_0000, 10'd0,    1, STAT_EMPTY, 0);
    add_row(KIND_REM_TAIL, 32'h0000_0000, 10'd0,    1, STAT_OK,    0);
    add_row(KIND_RD_POS,   32'h0000_0000, 10'd0,    1, STAT_OK,    0);
    add_row(KIND_RD_POS,   32'h0000_0000, 10'd255,  1, STAT_OK,    0);
    add_row(KIND_RD_POS,   32'h0000_0000, 10'd256,  1, STAT_RANGE, 0);
    add_row(KIND_RD_POS,   32'hFFFF_FFFF, 10'd1023, 1, STAT_RANGE, 0);
    add_row(KIND_INS_TAIL, 32'hFFFF_FFFF, 10'd0,    1, STAT_OK,    1);
    add_row(KIND_INS_HEAD, 32'h0000_0000, 10'd1023, 1, STAT_OK,    2);
    add_row(KIND_INS_HEAD, 32'h1234_5678, 10'd0,    1, STAT_OK,    3);
    add_row(KIND_RD_HEAD,  32'h0000_0000, 10'd0,    0, STAT_OK,    0);
    add_row(KIND_RD_TAIL,  32'h0000_0000, 10'd0,    0, STAT_OK,    0);
    add_row(KIND_RD_POS,   32'h0000_0000, 10'd1,    0, STAT_OK,    0);
    add_row(KIND_RD_POS,   32'h0000_0000, 10'd2,    0, STAT_OK,    0);
    add_row(KIND_RD_POS,   32'h0000_0000, 10'd3,    0, STAT_OK,    0);
    add_row(KIND_INS_TAIL, 32'hA5A5_5A5A, 10'd0,    0, STAT_OK,    0);
    add_row(KIND_RD_POS,   32'h0000_0000, 10'd3,    0, STAT_OK,    0);
    add_row(KIND_REM_HEAD, 32'h0000_0000, 10'd0,    0, STAT_OK,    0);
    add_row(KIND_RD_HEAD,  32'h0000_0000, 10'd0,    0, STAT_OK,    0);
    add_row(KIND_REM_TAIL, 32'h0000_0000, 10'd0,    0, STAT_OK,    0);
    add_row(KIND_RD_TAIL,  32'h0000_0000, 10'd0,    0, STAT_OK,    0);
    add_row(KIND_REM_TAIL, 32'h0000_0000, 10'd0,    0, STAT_OK,    0);
    add_row(KIND_REM_TAIL, 32'h0000_0000, 10'd0,    0, STAT_OK,    0);
    add_row(KIND_REM_TAIL, 32'h0000_0000, 10'd0,    0, STAT_OK,    0);

    // reset once, released away from the active edge
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_op(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

    // sender pause: let the whole directed part drain before going on
    hold_until_drained();

    repeat (MIX_ITEMS) send_op(random_op(MIX_BALANCED), 1'b0, none);

    // fill to capacity, then keep knocking on the full deque
    while (deque_fill < CAPACITY) send_op(random_op(MIX_FILL), 1'b0, none);
    n = 0;
    while (n < OVERFILL) begin
      send_op(random_op(MIX_FILL), 1'b0, none);
      n++;
    end

    // mixed traffic around a near-full wrapped ring, quiet at the end
    for (int i = 0; i < TAIL_ITEMS; i++) begin
      if (i >= TAIL_ITEMS - CALM_ITEMS) calm = 1'b1;
      send_op(random_op(MIX_BALANCED), 1'b0, none);
    end

    hold_until_drained();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard stop for a hung handshake
  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
